// File: rtl/brute_force_vector_knn_search_unit_defines.svh
// assertion macros for the knn search unit checker
// no dependencies
`ifndef BRUTE_FORCE_VECTOR_KNN_SEARCH_UNIT_DEFINES_SVH
`define BRUTE_FORCE_VECTOR_KNN_SEARCH_UNIT_DEFINES_SVH

// clocked assertion, switched off while reset is high
`define BFKNN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds through reset
`define BFKNN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bfknn_pkg.sv
// shared types, constants and codes for the knn search unit
// no dependencies
`default_nettype none

package bfknn_pkg;

   localparam int DEF_MAX_QUERIES = 8;
   localparam int DEF_MAX_LEN     = 128;
   localparam int DEF_MAX_K       = 8;

   localparam int DIST_W     = 48;
   localparam int SQ_W       = 34;
   localparam int LEN_W      = 11;
   localparam int NQ_W       = 5;
   localparam int K_W        = 5;
   localparam int FIFO_DEPTH = 4;

   localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_CAND = 2'd1;
   localparam logic [1:0] CMD_EMIT = 2'd2;

   localparam logic [2:0] CSR_VECTOR_LEN  = 3'd0;
   localparam logic [2:0] CSR_QUERY_COUNT = 3'd1;
   localparam logic [2:0] CSR_K_DEPTH     = 3'd2;
   localparam logic [2:0] CSR_OWN_TABLE   = 3'd3;
   localparam logic [2:0] CSR_OWN_SET     = 3'd4;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_CAND,
      OP_EMIT
   } op_kind_type;

   typedef struct packed {
      op_kind_type        kind;
      logic [2:0]         qi;
      logic [6:0]         ei;
      logic signed [15:0] sample;
      logic [15:0]        tab;
      logic [15:0]        set;
      logic               last;
   } op_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [NQ_W-1:0]  nq;
      logic [K_W-1:0]   k;
      logic [15:0]      own_table;
      logic [15:0]      own_set;
   } cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [15:0]       tab;
      logic [15:0]       set;
   } list_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Q_RD,
      ST_Q_SQ,
      ST_Q_ACC,
      ST_L_HEAD,
      ST_L_CMP,
      ST_SH_RD,
      ST_SH_WR,
      ST_L_PUT,
      ST_E_RD,
      ST_E_OUT
   } back_state_type;

endpackage

`default_nettype wire

// File: rtl/bfknn_front.sv
// front end: takes input transfers, classifies them and drops those without effect
// depends on bfknn_pkg
`default_nettype none

module bfknn_front
   import bfknn_pkg::*;
#(
   parameter int MAX_QUERIES = DEF_MAX_QUERIES,
   parameter int MAX_LEN     = DEF_MAX_LEN
) (
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [2:0]  req_query_index,
   input  wire logic [6:0]  req_element_index,
   input  wire logic [15:0] req_sample,
   input  wire logic [15:0] req_cand_table,
   input  wire logic [15:0] req_cand_set,
   input  wire cfg_type     cfg,
   input  wire logic        q_full,
   output logic             push,
   output op_type           op
);

   logic accept;
   logic keep;
   logic own;
   logic load_ok;
   logic [LEN_W-1:0] ei_ext;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign ei_ext    = LEN_W'(req_element_index);
   assign own       = (req_cand_table == cfg.own_table) && (req_cand_set == cfg.own_set);
   assign load_ok   = (NQ_W'(req_query_index) < NQ_W'(MAX_QUERIES))
                   && (ei_ext < LEN_W'(MAX_LEN));

   always_comb begin
      op.qi     = req_query_index;
      op.ei     = req_element_index;
      op.sample = req_sample;
      op.tab    = req_cand_table;
      op.set    = req_cand_set;
      op.last   = (ei_ext + LEN_W'(1)) == cfg.len;
      op.kind   = OP_LOAD;
      keep      = 1'b0;
      unique case (req_cmd)
         CMD_LOAD: begin
            op.kind = OP_LOAD;
            keep    = load_ok;
         end
         CMD_CAND: begin
            op.kind = OP_CAND;
            keep    = !own && (ei_ext < cfg.len);
         end
         CMD_EMIT: begin
            op.kind = OP_EMIT;
            keep    = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = accept && keep;

endmodule

`default_nettype wire

// File: rtl/bfknn_fifo.sv
// short operation queue between front end and back end
// depends on bfknn_pkg
`default_nettype none

module bfknn_fifo
   import bfknn_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   output logic        full,
   output logic        head_valid,
   output op_type      head,
   input  wire logic   pop
);

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   op_type        slot_ff [FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = count_ff == CW'(FIFO_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bfknn_back.sv
// back end: query store, distance accumulation, ranked lists and emission
// depends on bfknn_pkg
`default_nettype none

module bfknn_back
   import bfknn_pkg::*;
#(
   parameter int MAX_QUERIES = DEF_MAX_QUERIES,
   parameter int MAX_LEN     = DEF_MAX_LEN,
   parameter int MAX_K       = DEF_MAX_K
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        head_valid,
   input  wire op_type      head,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_out_query,
   output logic [2:0]       rsp_out_rank,
   output logic [DIST_W-1:0] rsp_out_distance,
   output logic [15:0]      rsp_out_table,
   output logic [15:0]      rsp_out_set,
   output logic             rsp_last
);

   localparam int QW     = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
   localparam int HW     = $clog2(MAX_QUERIES + 1);
   localparam int RW     = $clog2(MAX_K + 1);
   localparam int QDEPTH = MAX_QUERIES * MAX_LEN;
   localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int LDEPTH = MAX_QUERIES * MAX_K;
   localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;

   back_state_type state_ff, state_in;
   op_type         op_ff;
   logic [HW-1:0]  h_ff;
   logic [RW-1:0]  r_ff;
   logic [RW-1:0]  slot_ff;
   logic [SQ_W-1:0] sq_ff;
   logic [DIST_W-1:0] partial_ff [MAX_QUERIES];
   logic [RW-1:0]  tie_ff [MAX_QUERIES];
   logic [LDEPTH-1:0] list_vld_ff;
   logic           vcap_ff;
   list_entry_type list_rd_ff;
   logic [15:0]    q_rd_ff;

   logic [15:0]    qmem [QDEPTH];
   list_entry_type lmem [LDEPTH];

   logic           rsp_valid_ff;
   logic [2:0]     out_query_ff;
   logic [2:0]     out_rank_ff;
   logic [DIST_W-1:0] out_dist_ff;
   logic [15:0]    out_tab_ff;
   logic [15:0]    out_set_ff;
   logic           out_last_ff;

   logic [QW-1:0]  h_idx;
   logic           h_last;
   logic           r_last;
   logic [LAW-1:0] base;
   logic [DIST_W-1:0] d_cur;
   logic [DIST_W-1:0] head_dist;
   logic [RW-1:0]  cur_tie;
   logic           lt;
   logic           eq_fill;
   logic           out_free;
   logic           nq_zero;

   logic           q_we, q_re;
   logic [QAW-1:0] q_waddr, q_raddr;
   logic           l_re, l_we, l_wvld;
   logic [LAW-1:0] l_raddr, l_waddr;
   list_entry_type l_wdata;
   logic           out_load;
   logic           clr_all;
   logic           clr_part;

   logic signed [16:0] diff;
   logic [16:0]    mag;
   logic [DIST_W:0] sum;
   logic [DIST_W-1:0] acc_new;

   assign h_idx     = h_ff[QW-1:0];
   assign h_last    = (NQ_W'(h_ff) + NQ_W'(1)) == cfg.nq;
   assign r_last    = (K_W'(r_ff) + K_W'(1)) == cfg.k;
   assign base      = LAW'(h_idx) * LAW'(MAX_K);
   assign d_cur     = partial_ff[h_idx];
   assign head_dist = vcap_ff ? list_rd_ff.distance : DIST_ONES;
   assign cur_tie   = tie_ff[h_idx];
   assign lt        = d_cur < head_dist;
   assign eq_fill   = (d_cur == head_dist) && (K_W'(cur_tie) < cfg.k);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign nq_zero   = cfg.nq == '0;

   // squared difference and saturating accumulate
   assign diff    = {q_rd_ff[15], q_rd_ff} - {op_ff.sample[15], op_ff.sample};
   assign mag     = diff[16] ? 17'(-diff) : 17'(diff);
   assign sum     = (DIST_W+1)'(d_cur) + (DIST_W+1)'(sq_ff);
   assign acc_new = (op_ff.ei == '0) ? DIST_W'(sq_ff)
                  : (sum[DIST_W] ? DIST_ONES : sum[DIST_W-1:0]);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               unique case (head.kind)
                  OP_CAND: state_in = nq_zero ? ST_IDLE : ST_Q_RD;
                  OP_EMIT: state_in = nq_zero ? ST_IDLE : ST_E_RD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_Q_RD:   state_in = ST_Q_SQ;
         ST_Q_SQ:   state_in = ST_Q_ACC;
         ST_Q_ACC: begin
            if (h_last) begin
               state_in = op_ff.last ? ST_L_HEAD : ST_IDLE;
            end else begin
               state_in = ST_Q_RD;
            end
         end
         ST_L_HEAD: state_in = ST_L_CMP;
         ST_L_CMP: begin
            priority if (lt) begin
               state_in = (cfg.k > K_W'(1)) ? ST_SH_RD : ST_L_PUT;
            end else if (eq_fill) begin
               state_in = ST_L_PUT;
            end else begin
               state_in = h_last ? ST_IDLE : ST_L_HEAD;
            end
         end
         ST_SH_RD:  state_in = ST_SH_WR;
         ST_SH_WR:  state_in = (r_ff == RW'(1)) ? ST_L_PUT : ST_SH_RD;
         ST_L_PUT:  state_in = h_last ? ST_IDLE : ST_L_HEAD;
         ST_E_RD:   state_in = ST_E_OUT;
         ST_E_OUT: begin
            if (out_free) begin
               state_in = (r_last && h_last) ? ST_IDLE : ST_E_RD;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      q_we     = 1'b0;
      q_re     = 1'b0;
      l_re     = 1'b0;
      l_we     = 1'b0;
      l_wvld   = 1'b0;
      l_raddr  = base;
      l_waddr  = base + LAW'(slot_ff);
      l_wdata  = '{distance: d_cur, tab: op_ff.tab, set: op_ff.set};
      out_load = 1'b0;
      clr_all  = 1'b0;
      clr_part = 1'b0;
      q_waddr  = QAW'(head.qi) * QAW'(MAX_LEN) + QAW'(head.ei);
      q_raddr  = QAW'(h_idx) * QAW'(MAX_LEN) + QAW'(op_ff.ei);
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               unique case (head.kind)
                  OP_LOAD: q_we = 1'b1;
                  OP_CAND: clr_part = nq_zero && head.last;
                  OP_EMIT: clr_all = nq_zero;
                  default: q_we = 1'b0;
               endcase
            end
         end
         ST_Q_RD:   q_re = 1'b1;
         ST_L_HEAD: l_re = 1'b1;
         ST_L_CMP:  clr_part = !lt && !eq_fill && h_last;
         ST_SH_RD: begin
            l_re    = 1'b1;
            l_raddr = base + LAW'(r_ff) - LAW'(1);
         end
         ST_SH_WR: begin
            l_we    = 1'b1;
            l_waddr = base + LAW'(r_ff);
            l_wdata = list_rd_ff;
            l_wvld  = vcap_ff;
         end
         ST_L_PUT: begin
            l_we     = 1'b1;
            l_wvld   = 1'b1;
            clr_part = h_last;
         end
         ST_E_RD: begin
            l_re    = 1'b1;
            l_raddr = base + LAW'(r_ff);
         end
         ST_E_OUT: begin
            out_load = out_free;
            clr_all  = out_free && r_last && h_last;
         end
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h_ff         <= '0;
         r_ff         <= '0;
         list_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_QUERIES; i++) begin
            partial_ff[i] <= '0;
            tie_ff[i]     <= '0;
         end
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               h_ff <= '0;
               r_ff <= '0;
            end
            ST_Q_ACC: begin
               partial_ff[h_idx] <= acc_new;
               h_ff <= h_last ? '0 : h_ff + HW'(1);
            end
            ST_L_CMP: begin
               priority if (lt) begin
                  tie_ff[h_idx] <= RW'(1);
                  r_ff <= RW'(cfg.k - K_W'(1));
               end else if (eq_fill) begin
                  tie_ff[h_idx] <= cur_tie + RW'(1);
               end else begin
                  h_ff <= h_ff + HW'(1);
               end
            end
            ST_SH_WR: r_ff <= r_ff - RW'(1);
            ST_L_PUT: h_ff <= h_ff + HW'(1);
            ST_E_OUT: begin
               if (out_free) begin
                  if (r_last) begin
                     r_ff <= '0;
                     h_ff <= h_ff + HW'(1);
                  end else begin
                     r_ff <= r_ff + RW'(1);
                  end
               end
            end
            default: begin
               h_ff <= h_ff;
            end
         endcase
         if (l_we) begin
            list_vld_ff[l_waddr] <= l_wvld;
         end
         if (clr_part || clr_all) begin
            for (int i = 0; i < MAX_QUERIES; i++) begin
               partial_ff[i] <= '0;
            end
         end
         if (clr_all) begin
            list_vld_ff <= '0;
            for (int i = 0; i < MAX_QUERIES; i++) begin
               tie_ff[i] <= '0;
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= head;
      end
      if (state_ff == ST_Q_SQ) begin
         sq_ff <= SQ_W'(mag) * SQ_W'(mag);
      end
      if (state_ff == ST_L_CMP) begin
         slot_ff <= lt ? '0 : cur_tie;
      end
      if (l_re) begin
         vcap_ff <= list_vld_ff[l_raddr];
      end
      if (out_load) begin
         out_query_ff <= 3'(h_ff);
         out_rank_ff  <= 3'(r_ff);
         out_dist_ff  <= head_dist;
         out_tab_ff   <= vcap_ff ? list_rd_ff.tab : 16'd0;
         out_set_ff   <= vcap_ff ? list_rd_ff.set : 16'd0;
         out_last_ff  <= r_last && h_last;
      end
   end

   // query store
   always_ff @(posedge clock) begin
      if (q_we) begin
         qmem[q_waddr] <= head.sample;
      end
      if (q_re) begin
         q_rd_ff <= qmem[q_raddr];
      end
   end

   // list store
   always_ff @(posedge clock) begin
      if (l_we) begin
         lmem[l_waddr] <= l_wdata;
      end
      if (l_re) begin
         list_rd_ff <= lmem[l_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_query    = out_query_ff;
   assign rsp_out_rank     = out_rank_ff;
   assign rsp_out_distance = out_dist_ff;
   assign rsp_out_table    = out_tab_ff;
   assign rsp_out_set      = out_set_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

// File: rtl/brute_force_vector_knn_search_unit.sv
// Brute-force k-nearest-neighbour search by squared Euclidean distance.
// The front end takes one transfer per cycle into a four-entry queue while
// the queue is not full, and drops items without effect (own-set candidates,
// out-of-range elements, unknown commands). The back end handles one
// queued item at a time: a query load is written at dispatch; a candidate
// element is dispatched, then for each active query the query store is
// read, the difference squared and the distance accumulated; after a
// candidate's last element each query list has its head read and compared,
// and when the list changes, entries are shifted (read, write) as needed
// and the new entry is inserted; an emit is dispatched, then each result is
// read from the list and sent out, holding while the result side stalls.
// All active queries share the single squarer.
// Lists clear on emit and come out of reset empty with no clearing pass.
// depends on bfknn_pkg, bfknn_front, bfknn_fifo, bfknn_back
`default_nettype none

module brute_force_vector_knn_search_unit
   import bfknn_pkg::*;
#(
   parameter int MAX_QUERIES = DEF_MAX_QUERIES,
   parameter int MAX_LEN     = DEF_MAX_LEN,
   parameter int MAX_K       = DEF_MAX_K
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [2:0]  req_query_index,
   input  wire logic [6:0]  req_element_index,
   input  wire logic [15:0] req_sample,
   input  wire logic [15:0] req_cand_table,
   input  wire logic [15:0] req_cand_set,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_out_query,
   output logic [2:0]       rsp_out_rank,
   output logic [47:0]      rsp_out_distance,
   output logic [15:0]      rsp_out_table,
   output logic [15:0]      rsp_out_set,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   logic [7:0]  vector_len_ff;
   logic [3:0]  query_count_ff;
   logic [3:0]  k_depth_ff;
   logic [15:0] own_table_ff;
   logic [15:0] own_set_ff;
   cfg_type     cfg;
   logic        q_full;
   logic        push;
   op_type      push_op;
   logic        head_valid;
   op_type      head;
   logic        pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_len_ff  <= 8'd100;
         query_count_ff <= 4'd1;
         k_depth_ff     <= 4'd1;
         own_table_ff   <= '0;
         own_set_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VECTOR_LEN:  vector_len_ff  <= csr_data[7:0];
            CSR_QUERY_COUNT: query_count_ff <= csr_data[3:0];
            CSR_K_DEPTH:     k_depth_ff     <= csr_data[3:0];
            CSR_OWN_TABLE:   own_table_ff   <= csr_data;
            CSR_OWN_SET:     own_set_ff     <= csr_data;
            default:         own_set_ff     <= own_set_ff;
         endcase
      end
   end

   // effective sizes clamped to the built storage
   always_comb begin
      cfg.len = (LEN_W'(vector_len_ff) < LEN_W'(MAX_LEN))
              ? LEN_W'(vector_len_ff) : LEN_W'(MAX_LEN);
      cfg.nq  = (NQ_W'(query_count_ff) < NQ_W'(MAX_QUERIES))
              ? NQ_W'(query_count_ff) : NQ_W'(MAX_QUERIES);
      priority if (k_depth_ff == '0) begin
         cfg.k = K_W'(1);
      end else if (K_W'(k_depth_ff) < K_W'(MAX_K)) begin
         cfg.k = K_W'(k_depth_ff);
      end else begin
         cfg.k = K_W'(MAX_K);
      end
      cfg.own_table = own_table_ff;
      cfg.own_set   = own_set_ff;
   end

   bfknn_front #(
      .MAX_QUERIES (MAX_QUERIES),
      .MAX_LEN     (MAX_LEN)
   ) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_query_index   (req_query_index),
      .req_element_index (req_element_index),
      .req_sample        (req_sample),
      .req_cand_table    (req_cand_table),
      .req_cand_set      (req_cand_set),
      .cfg               (cfg),
      .q_full            (q_full),
      .push              (push),
      .op                (push_op)
   );

   bfknn_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   bfknn_back #(
      .MAX_QUERIES (MAX_QUERIES),
      .MAX_LEN     (MAX_LEN),
      .MAX_K       (MAX_K)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_query    (rsp_out_query),
      .rsp_out_rank     (rsp_out_rank),
      .rsp_out_distance (rsp_out_distance),
      .rsp_out_table    (rsp_out_table),
      .rsp_out_set      (rsp_out_set),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/bfknn_checker.sv
// port-level checks on the result channel of the knn search unit, with its bind
// depends on brute_force_vector_knn_search_unit_defines.svh
`default_nettype none

`include "brute_force_vector_knn_search_unit_defines.svh"

module bfknn_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_out_query,
   input wire logic [2:0]  rsp_out_rank,
   input wire logic [47:0] rsp_out_distance,
   input wire logic [15:0] rsp_out_table,
   input wire logic [15:0] rsp_out_set,
   input wire logic        rsp_last
);

   logic       xfer;
   logic       in_run_ff;
   logic [2:0] prev_q_ff;
   logic [2:0] prev_r_ff;

   assign xfer = rsp_valid && !rsp_stall;

   // tracks position within an emitted run
   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
         prev_q_ff <= '0;
         prev_r_ff <= '0;
      end else if (xfer) begin
         in_run_ff <= !rsp_last;
         prev_q_ff <= rsp_out_query;
         prev_r_ff <= rsp_out_rank;
      end
   end

   `BFKNN_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, $past(reset) |-> !rsp_valid, "result valid straight after reset")

   `BFKNN_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_distance) && $stable(rsp_out_query) && $stable(rsp_out_rank) && $stable(rsp_out_table) && $stable(rsp_out_set) && $stable(rsp_last)), "stalled result changed")

   `BFKNN_ASSERT(a_run_start, clock, reset, (xfer && !in_run_ff) |-> (rsp_out_query == 3'd0 && rsp_out_rank == 3'd0), "emitted run does not start at first entry")

   `BFKNN_ASSERT(a_run_order, clock, reset, (xfer && in_run_ff) |-> ((rsp_out_query == prev_q_ff && rsp_out_rank == prev_r_ff + 3'd1) || (rsp_out_query == prev_q_ff + 3'd1 && rsp_out_rank == 3'd0)), "emitted entries out of order")

endmodule

bind brute_force_vector_knn_search_unit bfknn_checker u_bfknn_checker (.*);

`default_nettype wire

// File: sim/tb_brute_force_vector_knn_search_unit.sv
// self-checking testbench for brute_force_vector_knn_search_unit: directed and random
// query loads, candidate streams and list emits, checked against an in-bench predictor
// depends on bfknn_pkg and brute_force_vector_knn_search_unit
`timescale 1ns / 1ps

module tb_brute_force_vector_knn_search_unit;
   import bfknn_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         SETTLE      = 400;
   localparam int         LONG_HOLD   = 400;

   typedef struct {
      logic [1:0]  cmd;
      logic [2:0]  qi;
      logic [6:0]  ei;
      logic [15:0] sample;
      logic [15:0] tab;
      logic [15:0] set;
   } knn_req_type;

   typedef struct {
      logic [2:0]  query;
      logic [2:0]  rank;
      logic [47:0] distance;
      logic [15:0] tab;
      logic [15:0] set;
      logic        last;
   } exp_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = '0;
   logic [2:0]  req_query_index = '0;
   logic [6:0]  req_element_index = '0;
   logic [15:0] req_sample = '0;
   logic [15:0] req_cand_table = '0;
   logic [15:0] req_cand_set = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_out_query;
   logic [2:0]  rsp_out_rank;
   logic [47:0] rsp_out_distance;
   logic [15:0] rsp_out_table;
   logic [15:0] rsp_out_set;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   brute_force_vector_knn_search_unit DUT (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [7:0]  cur_len;
   logic [3:0]  cur_nq;
   logic [3:0]  cur_k;
   logic [15:0] cur_own_tab;
   logic [15:0] cur_own_set;
   logic [15:0] query_mem [0:1023];
   logic [47:0] acc_dist [0:7];
   logic [47:0] best_dist [0:63];
   logic [15:0] best_tab [0:63];
   logic [15:0] best_set [0:63];
   logic [3:0]  ties [0:7];

   knn_req_type   pending_reqs[$];
   exp_entry_type expected_entries[$];
   int          fails = 0;
   int          cycles = 0;
   bit          press_req = 0;
   bit          press_done = 0;

   function automatic void clear_lists();
      for (int i = 0; i < 64; i++) begin
         best_dist[i] = '1;
         best_tab[i] = '0;
         best_set[i] = '0;
      end
      for (int h = 0; h < 8; h++) begin
         ties[h] = '0;
         acc_dist[h] = '0;
      end
   endfunction

   function automatic void predict_knn(knn_req_type r);
      int len, nq, k, b;
      int d;
      longint unsigned sq, s;
      exp_entry_type e;
      len = (cur_len < 128) ? cur_len : 128;
      nq = (cur_nq < 8) ? cur_nq : 8;
      k = (cur_k < 1) ? 1 : ((cur_k < 8) ? cur_k : 8);
      case (r.cmd)
         CMD_LOAD: query_mem[r.qi * 128 + r.ei] = r.sample;
         CMD_CAND: begin
            if ((r.tab == cur_own_tab && r.set == cur_own_set) || r.ei >= len) return;
            for (int h = 0; h < nq; h++) begin
               d = int'($signed(query_mem[h * 128 + r.ei])) - int'($signed(r.sample));
               sq = longint'(d) * longint'(d);
               if (r.ei == 0) acc_dist[h] = sq[47:0];
               else begin
                  s = acc_dist[h] + sq;
                  acc_dist[h] = (s > 64'hFFFF_FFFF_FFFF) ? '1 : s[47:0];
               end
            end
            if (r.ei == len - 1) begin
               for (int h = 0; h < nq; h++) begin
                  b = h * 8;
                  if (acc_dist[h] < best_dist[b]) begin
                     for (int m = k - 1; m >= 1; m--) begin
                        best_dist[b + m] = best_dist[b + m - 1];
                        best_tab[b + m] = best_tab[b + m - 1];
                        best_set[b + m] = best_set[b + m - 1];
                     end
                     best_dist[b] = acc_dist[h];
                     best_tab[b] = r.tab;
                     best_set[b] = r.set;
                     ties[h] = 1;
                  end else if (acc_dist[h] == best_dist[b] && ties[h] < k) begin
                     best_dist[b + ties[h]] = acc_dist[h];
                     best_tab[b + ties[h]] = r.tab;
                     best_set[b + ties[h]] = r.set;
                     ties[h] = ties[h] + 1;
                  end
               end
               for (int h = 0; h < 8; h++) acc_dist[h] = '0;
            end
         end
         CMD_EMIT: begin
            for (int h = 0; h < nq; h++)
               for (int q = 0; q < k; q++) begin
                  e.query = h[2:0];
                  e.rank = q[2:0];
                  e.distance = best_dist[h * 8 + q];
                  e.tab = best_tab[h * 8 + q];
                  e.set = best_set[h * 8 + q];
                  e.last = (h == nq - 1 && q == k - 1);
                  expected_entries.push_back(e);
               end
            clear_lists();
         end
         default: ;
      endcase
   endfunction

   function automatic void queue_req(logic [1:0] cmd, logic [2:0] qi, logic [6:0] ei,
                                     logic [15:0] smp, logic [15:0] tab, logic [15:0] set);
      knn_req_type r;
      r.cmd = cmd;
      r.qi = qi;
      r.ei = ei;
      r.sample = smp;
      r.tab = tab;
      r.set = set;
      predict_knn(r);
      pending_reqs.push_back(r);
   endfunction

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_entries.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VECTOR_LEN:  cur_len = data[7:0];
         CSR_QUERY_COUNT: cur_nq = data[3:0];
         CSR_K_DEPTH:     cur_k = data[3:0];
         CSR_OWN_TABLE:   cur_own_tab = data;
         CSR_OWN_SET:     cur_own_set = data;
         default: ;
      endcase
   endtask

   task automatic configure(int len, int nq, int k, logic [15:0] ot, logic [15:0] os);
      wait_idle();
      csr_write(CSR_VECTOR_LEN, 16'(len));
      csr_write(CSR_QUERY_COUNT, 16'(nq));
      csr_write(CSR_K_DEPTH, 16'(k));
      csr_write(CSR_OWN_TABLE, ot);
      csr_write(CSR_OWN_SET, os);
   endtask

   function automatic logic [15:0] pick_sample(int mode);
      return (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 6) - 3);
   endfunction

   // loads for every active query, then candidates (some cut short) with some noise, emit, repeat
   task automatic random_phase(int len, int nq, int k, int ncand);
      logic [15:0] ot, os, tab, set;
      logic [15:0] prev [0:127];
      int mode, cut;
      ot = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
      os = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(0, 3));
      configure(len, nq, k, ot, os);
      mode = $urandom_range(0, 1);
      for (int i = 0; i < 128; i++) prev[i] = pick_sample(mode);
      for (int h = 0; h < ((nq < 8) ? nq : 8); h++)
         for (int i = 0; i < len; i++)
            queue_req(CMD_LOAD, 3'(h), 7'(i), pick_sample(mode), 16'($urandom), 16'($urandom));
      for (int rep = 0; rep < 2; rep++) begin
         for (int c = 0; c < ncand; c++) begin
            case ($urandom_range(0, 9))
               0: begin tab = ot; set = os; end
               1: begin tab = 16'($urandom); set = 16'($urandom); end
               default: begin tab = 16'($urandom_range(0, 3)); set = 16'($urandom_range(0, 3)); end
            endcase
            cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : len;
            for (int i = 0; i < cut; i++) begin
               if (c == 0 || $urandom_range(0, 2) != 0) prev[i % 128] = pick_sample(mode);
               queue_req(CMD_CAND, 3'($urandom), 7'(i), prev[i % 128], tab, set);
               if ($urandom_range(0, 29) == 0)
                  queue_req($urandom_range(0, 1) ? CMD_UNKNOWN : CMD_CAND, 3'($urandom),
                            7'($urandom_range(len, 127)), 16'($urandom), 16'($urandom),
                            16'($urandom));
            end
         end
         queue_req(CMD_EMIT, 3'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      end
   endtask

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      knn_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_cmd <= r.cmd;
            req_query_index <= r.qi;
            req_element_index <= r.ei;
            req_sample <= r.sample;
            req_cand_table <= r.tab;
            req_cand_set <= r.set;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern plus one long hold-off
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (press_req && !press_done && rsp_valid) begin
         press_done <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         case ((cycles / 40) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      exp_entry_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_entries.size() == 0) begin
            $error("unexpected result transfer");
            fails++;
         end else begin
            e = expected_entries.pop_front();
            if (rsp_out_query !== e.query) begin
               $error("out_query: expected %0d got %0d", e.query, rsp_out_query); fails++;
            end
            if (rsp_out_rank !== e.rank) begin
               $error("out_rank: expected %0d got %0d", e.rank, rsp_out_rank); fails++;
            end
            if (rsp_out_distance !== e.distance) begin
               $error("out_distance: expected %h got %h", e.distance, rsp_out_distance);
               fails++;
            end
            if (rsp_out_table !== e.tab) begin
               $error("out_table: expected %h got %h", e.tab, rsp_out_table); fails++;
            end
            if (rsp_out_set !== e.set) begin
               $error("out_set: expected %h got %h", e.set, rsp_out_set); fails++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d got %0d", e.last, rsp_last); fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("brute_force_vector_knn_search_unit regression: fail");
         $finish;
      end
   end

   initial begin
      cur_len = 8'd100;
      cur_nq = 4'd1;
      cur_k = 4'd1;
      cur_own_tab = '0;
      cur_own_set = '0;
      clear_lists();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, ties, own set, out-of-range element, unknown command
      configure(2, 2, 3, 16'd5, 16'd6);
      queue_req(CMD_LOAD, 3'd0, 7'd0, 16'h8000, '0, '0);
      queue_req(CMD_LOAD, 3'd0, 7'd1, 16'h7FFF, '0, '0);
      queue_req(CMD_LOAD, 3'd1, 7'd0, 16'h0000, '0, '0);
      queue_req(CMD_LOAD, 3'd1, 7'd1, 16'hFFFF, '0, '0);
      queue_req(CMD_LOAD, 3'd7, 7'd127, 16'h1234, 16'hFFFF, 16'hFFFF);
      queue_req(CMD_CAND, 3'd0, 7'd0, 16'h7FFF, 16'd1, 16'd1);
      queue_req(CMD_CAND, 3'd0, 7'd1, 16'h8000, 16'd1, 16'd1);
      queue_req(CMD_CAND, 3'd0, 7'd0, 16'h0000, 16'd5, 16'd6);
      queue_req(CMD_CAND, 3'd0, 7'd1, 16'h0000, 16'd5, 16'd6);
      queue_req(CMD_CAND, 3'd0, 7'd0, 16'h0001, 16'd2, 16'd3);
      queue_req(CMD_CAND, 3'd0, 7'd127, 16'h0000, 16'd2, 16'd3);
      queue_req(CMD_UNKNOWN, 3'd7, 7'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_req(CMD_CAND, 3'd0, 7'd1, 16'hFFFF, 16'd2, 16'd3);
      queue_req(CMD_CAND, 3'd0, 7'd0, 16'h0001, 16'd4, 16'd4);
      queue_req(CMD_CAND, 3'd0, 7'd1, 16'hFFFF, 16'd4, 16'd4);
      queue_req(CMD_CAND, 3'd0, 7'd0, 16'h0001, 16'hFFFF, 16'hFFFF);
      queue_req(CMD_CAND, 3'd0, 7'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_req(CMD_CAND, 3'd0, 7'd0, 16'h0000, 16'd7, 16'd7);
      queue_req(CMD_CAND, 3'd0, 7'd1, 16'h0000, 16'd7, 16'd7);
      queue_req(CMD_EMIT, 3'd0, 7'd0, '0, '0, '0);
      // zero query count still clears, then no results
      configure(2, 0, 1, 16'hFFFF, 16'hFFFF);
      queue_req(CMD_CAND, 3'd0, 7'd0, 16'h0100, 16'd1, 16'd1);
      queue_req(CMD_CAND, 3'd0, 7'd1, 16'h0100, 16'd1, 16'd1);
      queue_req(CMD_EMIT, 3'd0, 7'd0, '0, '0, '0);
      // k shrinks after updates
      configure(2, 2, 3, 16'd0, 16'd0);
      queue_req(CMD_CAND, 3'd0, 7'd0, 16'h0000, 16'd9, 16'd9);
      queue_req(CMD_CAND, 3'd0, 7'd1, 16'h0000, 16'd9, 16'd9);
      wait_idle();
      csr_write(CSR_K_DEPTH, 16'd1);
      queue_req(CMD_EMIT, 3'd0, 7'd0, '0, '0, '0);

      random_phase(1, 8, 8, 6);
      press_req = 1;
      random_phase(4, 2, 2, 3);
      random_phase(3, 0, 4, 2);

      wait_idle();
      if (fails == 0)
         $display("brute_force_vector_knn_search_unit regression: pass");
      else
         $display("brute_force_vector_knn_search_unit regression: fail");
      $finish;
   end

endmodule
